// ----- sv/gdd_pkg.sv -----
package gdd_pkg;

    localparam int YearW    = 14;
    localparam int MonthW   = 4;
    localparam int DayW     = 5;
    localparam int OrdW     = 9;
    localparam int DaysW    = 22;
    localparam int DiffW    = 23;
    localparam int CentW    = 8;   // year / 100, at most 163 for a 14-bit year
    localparam int RemW     = 7;   // year % 100
    localparam int LeapsW   = 12;  // leap years before year, at most 2425

    localparam int InDataW  = 48;
    localparam int OutDataW = 48;

    // four date stages plus the output register
    localparam int PipeDepth = 5;

    localparam logic [YearW-1:0]  YearMax     = 14'd9999;
    localparam logic [YearW-1:0]  DefYear     = 14'd1970;
    localparam logic [CentW-1:0]  DefCent     = 8'd19;
    localparam logic [RemW-1:0]   DefRem      = 7'd70;
    localparam logic [MonthW-1:0] MonthJan    = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
    localparam logic [MonthW-1:0] MonthDec    = 4'd12;

    // year / 100 as (year * CentMul) >> CentShift, exact below 43690
    localparam int                CentShift   = 21;
    localparam logic [14:0]       CentMul     = 15'd20972;

    typedef struct packed {
        logic             valid;
        logic [OrdW-1:0]  ordinal;
        logic [DaysW-1:0] days;
    } t_date_res;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        case (m)
            4'd2:                     len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m);
        logic [OrdW-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- sv/gdd_date.sv -----
// Four-stage date front end: century split, check and substitute,
// ordinal and year base, day number since 0000-01-01.
module gdd_date (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [gdd_pkg::YearW-1:0]      i_year,
    input  logic [gdd_pkg::MonthW-1:0]     i_month,
    input  logic [gdd_pkg::DayW-1:0]       i_day,
    output gdd_pkg::t_date_res             o_res
);

    // stage 1
    logic [gdd_pkg::YearW-1:0]  r_y1,  n_y1;
    logic [gdd_pkg::MonthW-1:0] r_m1;
    logic [gdd_pkg::DayW-1:0]   r_d1;
    logic [gdd_pkg::CentW-1:0]  r_q1,  n_q1;
    logic [28:0]                w_prod;

    // stage 2
    logic [gdd_pkg::YearW-1:0]  r_y2,  n_y2;
    logic [gdd_pkg::CentW-1:0]  r_q2,  n_q2;
    logic [gdd_pkg::RemW-1:0]   r_r2,  n_r2;
    logic [gdd_pkg::MonthW-1:0] r_m2,  n_m2;
    logic [gdd_pkg::DayW-1:0]   r_d2,  n_d2;
    logic                       r_lp2, n_lp2;
    logic                       r_ok2, n_ok2;
    logic [gdd_pkg::RemW-1:0]   w_rem;
    logic [gdd_pkg::DayW-1:0]   w_len;
    logic                       w_leap;

    // stage 3
    logic [gdd_pkg::DaysW-1:0]  r_y365, n_y365;
    logic [gdd_pkg::LeapsW-1:0] r_lps3, n_lps3;
    logic [gdd_pkg::OrdW-1:0]   r_ord3, n_ord3;
    logic                       r_ok3;
    logic [14:0]                w_quad;
    logic [14:0]                w_lsum;

    // stage 4
    logic [gdd_pkg::DaysW-1:0]  r_days4, n_days4;
    logic [gdd_pkg::OrdW-1:0]   r_ord4;
    logic                       r_ok4;

    always_comb begin
        w_prod = 29'(i_year) * 29'(gdd_pkg::CentMul);
        n_q1   = w_prod[gdd_pkg::CentShift +: gdd_pkg::CentW];
        n_y1   = i_year;
    end

    always_comb begin
        w_rem  = gdd_pkg::RemW'(r_y1 - 14'({6'd0, r_q1} * 14'd100));
        w_leap = (r_y1[1:0] == 2'd0) && ((w_rem != '0) || (r_q1[1:0] == 2'd0));
        w_len  = (r_m1 == gdd_pkg::MonthFeb && w_leap) ? 5'd29 : gdd_pkg::month_len(r_m1);
        n_ok2  = (r_y1 <= gdd_pkg::YearMax) && (r_m1 >= gdd_pkg::MonthJan)
              && (r_m1 <= gdd_pkg::MonthDec) && (r_d1 != '0) && (r_d1 <= w_len);
        if (n_ok2) begin
            n_y2  = r_y1;
            n_q2  = r_q1;
            n_r2  = w_rem;
            n_m2  = r_m1;
            n_d2  = r_d1;
            n_lp2 = w_leap;
        end else begin
            n_y2  = gdd_pkg::DefYear;
            n_q2  = gdd_pkg::DefCent;
            n_r2  = gdd_pkg::DefRem;
            n_m2  = gdd_pkg::MonthJan;
            n_d2  = 5'd1;
            n_lp2 = 1'b0;
        end
    end

    // leaps before y: ceil(y/4) - ceil(y/100) + ceil(y/400), with y = 100q + r
    always_comb begin
        w_quad = (15'(r_y2) + 15'd3) >> 2;
        w_lsum = w_quad - 15'(r_q2) - 15'(r_r2 != '0)
               + 15'(r_q2 >> 2) + 15'((r_q2[1:0] != 2'd0) || (r_r2 != '0));
        n_lps3 = w_lsum[gdd_pkg::LeapsW-1:0];
        n_y365 = 22'(r_y2) * 22'd365;
        n_ord3 = gdd_pkg::days_before(r_m2) + 9'(r_d2)
               + 9'((r_m2 > gdd_pkg::MonthFeb) && r_lp2);
        n_days4 = r_y365 + 22'(r_lps3) + 22'(r_ord3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1    <= n_y1;
            r_m1    <= i_month;
            r_d1    <= i_day;
            r_q1    <= n_q1;
            r_y2    <= n_y2;
            r_q2    <= n_q2;
            r_r2    <= n_r2;
            r_m2    <= n_m2;
            r_d2    <= n_d2;
            r_lp2   <= n_lp2;
            r_ok2   <= n_ok2;
            r_y365  <= n_y365;
            r_lps3  <= n_lps3;
            r_ord3  <= n_ord3;
            r_ok3   <= r_ok2;
            r_days4 <= n_days4;
            r_ord4  <= r_ord3;
            r_ok4   <= r_ok3;
        end
    end

    assign o_res.valid   = r_ok4;
    assign o_res.ordinal = r_ord4;
    assign o_res.days    = r_days4;

endmodule

// ----- sv/gregorian_date_difference.sv -----
// Gregorian date difference. Each request carries two dates A and B (year, month,
// day). Each date is checked against the Gregorian calendar (leap year: divisible
// by 4, not by 100 unless by 400; years above 9999 rejected); a bad date is
// replaced by 1970-01-01 and flagged with valid = 0. The result gives both flags,
// both days of the year and the signed day count A - B. Fully pipelined: one
// request per cycle unless the pipe holds (four date stages, one
// subtract/output stage). The whole pipe moves together; it holds when the
// output register is full and not taken, so back-pressure reaches the input
// in the same cycle. No reset needed for data, only the valid bits clear.
module gregorian_date_difference (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18],
    // year_b[36:23], month_b[40:37], day_b[45:41], zero[47:46]
    input  logic [gdd_pkg::InDataW-1:0]    i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // valid_a[0], valid_b[1], ordinal_a[10:2], ordinal_b[19:11],
    // day_difference[42:20] (signed), zero[47:43]
    output logic [gdd_pkg::OutDataW-1:0]   o_m_axis_tdata
);

    logic [gdd_pkg::PipeDepth-1:0] r_vld, n_vld;
    logic                          w_adv;
    gdd_pkg::t_date_res            w_res_a, w_res_b;
    logic [gdd_pkg::OutDataW-1:0]  r_out, n_out;
    logic [gdd_pkg::DiffW-1:0]     w_diff;

    // whole pipe advances unless the output holds an untaken result
    assign w_adv           = !r_vld[gdd_pkg::PipeDepth-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    gdd_date u_date_a (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_year  (i_s_axis_tdata[13:0]),
        .i_month (i_s_axis_tdata[17:14]),
        .i_day   (i_s_axis_tdata[22:18]),
        .o_res   (w_res_a)
    );

    gdd_date u_date_b (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_year  (i_s_axis_tdata[36:23]),
        .i_month (i_s_axis_tdata[40:37]),
        .i_day   (i_s_axis_tdata[45:41]),
        .o_res   (w_res_b)
    );

    // day numbers fit in 22 bits, so the 23-bit difference never overflows
    always_comb begin
        w_diff = 23'(w_res_a.days) - 23'(w_res_b.days);
        n_out  = {5'd0, w_diff, w_res_b.ordinal, w_res_a.ordinal,
                  w_res_b.valid, w_res_a.valid};
        n_vld  = {r_vld[gdd_pkg::PipeDepth-2:0], i_s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_vld[gdd_pkg::PipeDepth-1];
    assign o_m_axis_tdata  = r_out;

    // a request taken at the input always lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted request not in first stage");

    // ordinals stay within 1..366 on every delivered result
    a_ord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out[10:2] != 9'd0 && r_out[10:2] <= 9'd366
                          && r_out[19:11] != 9'd0 && r_out[19:11] <= 9'd366))
        else $error("ordinal out of range");

    // two substituted dates are both 1970-01-01: zero difference
    a_subst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_out[0] && !r_out[1]) |->
            (r_out[42:20] == 23'd0 && r_out[10:2] == 9'd1 && r_out[19:11] == 9'd1))
        else $error("substituted dates give nonzero difference");

endmodule

// ----- verif/tb_gregorian_date_difference.sv -----
`timescale 1ns / 100ps

// Block-level bench for the Gregorian day-difference pipe.
// Each request carries two dates, and each one gives one result. A local
// predictor works out the validity flags, the days of the year and the signed
// day count A - B for every accepted request, and queues the expectation. A
// monitor pops the oldest expectation on every accepted result and compares
// it field by field. Both stream sides idle in random bursts, except in the
// closing phase, which runs back to back.
module tb_gregorian_date_difference;

    // Expected content of one result beat
    typedef struct packed {
        logic                             valid_a;
        logic                             valid_b;
        logic [gdd_pkg::OrdW-1:0]         ordinal_a;
        logic [gdd_pkg::OrdW-1:0]         ordinal_b;
        logic signed [gdd_pkg::DiffW-1:0] day_difference;
    } t_diff_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    // year_a, month_a, day_a, year_b, month_b, day_b, zero pad (low bit first)
    logic [gdd_pkg::InDataW-1:0]   i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // valid_a, valid_b, ordinal_a, ordinal_b, day_difference, zero pad
    logic [gdd_pkg::OutDataW-1:0]  o_m_axis_tdata;

    t_diff_result expected_results_q[$];

    int  mismatch_count = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  invalid_dates = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_stalls = 1'b1;
    int  stall_left = 0;

    gregorian_date_difference i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        case (m)
            2:          return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Validates one date, substitutes the epoch default when bad, and gives
    // its day of year plus a day serial counted from the start of year 0.
    function automatic void resolve_date(input int unsigned y, input int unsigned m,
                                         input int unsigned d, output bit ok,
                                         output int unsigned ord, output int serial);
        int unsigned yy;
        int unsigned mm;
        int unsigned dd;
        ok = (y <= 9999) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(y, m));
        yy = ok ? y : 1970;
        mm = ok ? m : 1;
        dd = ok ? d : 1;
        ord = dd;
        for (int unsigned k = 1; k < mm; k++)
            ord += month_days(yy, k);
        // whole years before yy, leap days counted in closed form
        serial = yy * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400 + ord;
    endfunction

    function automatic t_diff_result predict_date_difference(
            logic [gdd_pkg::YearW-1:0] ya, logic [gdd_pkg::MonthW-1:0] ma,
            logic [gdd_pkg::DayW-1:0] da, logic [gdd_pkg::YearW-1:0] yb,
            logic [gdd_pkg::MonthW-1:0] mb, logic [gdd_pkg::DayW-1:0] db);
        t_diff_result r;
        bit           ok_a;
        bit           ok_b;
        int unsigned  ord_a;
        int unsigned  ord_b;
        int           serial_a;
        int           serial_b;
        int           diff;
        resolve_date(ya, ma, da, ok_a, ord_a, serial_a);
        resolve_date(yb, mb, db, ok_b, ord_b, serial_b);
        diff = serial_a - serial_b;
        r.valid_a        = ok_a;
        r.valid_b        = ok_b;
        r.ordinal_a      = ord_a[gdd_pkg::OrdW-1:0];
        r.ordinal_b      = ord_b[gdd_pkg::OrdW-1:0];
        r.day_difference = diff[gdd_pkg::DiffW-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: optional idle burst, then hold tvalid until taken.
    // tvalid stays high after acceptance so back-to-back requests never
    // lower and raise it in one step.
    // ------------------------------------------------------------------
    task automatic send_dates(logic [gdd_pkg::YearW-1:0] ya, logic [gdd_pkg::MonthW-1:0] ma,
                              logic [gdd_pkg::DayW-1:0] da, logic [gdd_pkg::YearW-1:0] yb,
                              logic [gdd_pkg::MonthW-1:0] mb, logic [gdd_pkg::DayW-1:0] db);
        t_diff_result r;
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, db, mb, yb, da, ma, ya};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        r = predict_date_difference(ya, ma, da, yb, mb, db);
        expected_results_q.push_back(r);
        requests_sent++;
        invalid_dates += !r.valid_a + !r.valid_b;
    endtask

    task automatic rand_valid_date(output logic [gdd_pkg::YearW-1:0] y,
                                   output logic [gdd_pkg::MonthW-1:0] m,
                                   output logic [gdd_pkg::DayW-1:0] d);
        int unsigned yy;
        int unsigned mm;
        int unsigned dd;
        case ($urandom_range(0, 9))
            0:       yy = $urandom_range(0, 3);
            1:       yy = $urandom_range(9996, 9999);
            2:       yy = 100 * $urandom_range(0, 99);   // century years
            default: yy = $urandom_range(0, 9999);
        endcase
        mm = $urandom_range(1, 12);
        // favor the last days of the month, where leap rules bite
        dd = ($urandom_range(0, 3) == 0) ? month_days(yy, mm)
                                         : $urandom_range(1, month_days(yy, mm));
        y = yy[gdd_pkg::YearW-1:0];
        m = mm[gdd_pkg::MonthW-1:0];
        d = dd[gdd_pkg::DayW-1:0];
    endtask

    task automatic rand_any_date(output logic [gdd_pkg::YearW-1:0] y,
                                 output logic [gdd_pkg::MonthW-1:0] m,
                                 output logic [gdd_pkg::DayW-1:0] d);
        int unsigned raw_y;
        int unsigned raw_m;
        int unsigned raw_d;
        raw_y = $urandom();
        raw_m = $urandom();
        raw_d = $urandom();
        y = raw_y[gdd_pkg::YearW-1:0];
        m = raw_m[gdd_pkg::MonthW-1:0];
        d = raw_d[gdd_pkg::DayW-1:0];
    endtask

    // ------------------------------------------------------------------
    // Test phases
    // ------------------------------------------------------------------
    task automatic test_range_extremes();
        send_dates(14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31);
        send_dates(14'd9999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1);
        send_dates(14'd9999, 4'd12, 5'd31, 14'd9999, 4'd12, 5'd31);   // same date
        send_dates(14'd1970, 4'd1, 5'd1, 14'd1970, 4'd1, 5'd1);
        send_dates(14'd0, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1);
    endtask

    task automatic test_leap_rules();
        send_dates(14'd2000, 4'd2, 5'd29, 14'd1900, 4'd2, 5'd28);   // 400 rule
        send_dates(14'd1900, 4'd2, 5'd29, 14'd2024, 4'd2, 5'd29);   // 100 rule bad
        send_dates(14'd2023, 4'd2, 5'd29, 14'd0, 4'd2, 5'd29);      // plain year bad, year 0 leap
        send_dates(14'd2024, 4'd12, 5'd31, 14'd2023, 4'd12, 5'd31); // day 366 vs 365
        send_dates(14'd2400, 4'd3, 5'd1, 14'd2100, 4'd3, 5'd1);
    endtask

    task automatic test_invalid_dates();
        send_dates(14'd2020, 4'd0, 5'd10, 14'd2020, 4'd13, 5'd10);  // month out of range
        send_dates(14'd2020, 4'd15, 5'd31, 14'd2020, 4'd5, 5'd0);   // top month, day zero
        send_dates(14'd2021, 4'd4, 5'd31, 14'd2021, 4'd11, 5'd31);  // past 30-day month end
        send_dates(14'd10000, 4'd1, 5'd1, 14'd16383, 4'd15, 5'd31); // years beyond range
        send_dates(14'd16383, 4'd12, 5'd31, 14'd9999, 4'd1, 5'd1);
        send_dates(14'd0, 4'd0, 5'd0, 14'd0, 4'd0, 5'd0);           // all zero
        send_dates(14'd1970, 4'd1, 5'd1, 14'd1969, 4'd2, 5'd30);    // bad B equals default A
    endtask

    task automatic test_random_mixed(int count);
        logic [gdd_pkg::YearW-1:0]  ya, yb;
        logic [gdd_pkg::MonthW-1:0] ma, mb;
        logic [gdd_pkg::DayW-1:0]   da, db;
        repeat (count) begin
            // mostly calendar dates, some raw field noise on either side
            if ($urandom_range(0, 9) < 8) rand_valid_date(ya, ma, da);
            else                          rand_any_date(ya, ma, da);
            if ($urandom_range(0, 9) < 8) rand_valid_date(yb, mb, db);
            else                          rand_any_date(yb, mb, db);
            send_dates(ya, ma, da, yb, mb, db);
        end
    endtask

    task automatic test_field_noise(int count);
        logic [gdd_pkg::YearW-1:0]  ya, yb;
        logic [gdd_pkg::MonthW-1:0] ma, mb;
        logic [gdd_pkg::DayW-1:0]   da, db;
        repeat (count) begin
            rand_any_date(ya, ma, da);
            rand_any_date(yb, mb, db);
            send_dates(ya, ma, da, yb, mb, db);
        end
    endtask

    // Sender holds off until the pipe has returned every pending result
    task automatic test_drain_pause();
        test_random_mixed(40);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results_q.size() != 0) @(posedge i_clk);
        test_random_mixed(40);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on tready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Result monitor: compare each accepted beat to the oldest expectation
    always @(posedge i_clk) begin
        t_diff_result want;
        t_diff_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.valid_a        = o_m_axis_tdata[0];
            got.valid_b        = o_m_axis_tdata[1];
            got.ordinal_a      = o_m_axis_tdata[10:2];
            got.ordinal_b      = o_m_axis_tdata[19:11];
            got.day_difference = o_m_axis_tdata[42:20];
            if (expected_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: tdata=%h", $realtime,
                             o_m_axis_tdata);
            end else begin
                want = expected_results_q.pop_front();
                results_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp va=%b vb=%b oa=%0d ob=%0d diff=%0d",
                                  " | got va=%b vb=%b oa=%0d ob=%0d diff=%0d"}, $realtime,
                                 want.valid_a, want.valid_b, want.ordinal_a,
                                 want.ordinal_b, want.day_difference, got.valid_a,
                                 got.valid_b, got.ordinal_a, got.ordinal_b,
                                 got.day_difference);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_extremes();
        test_leap_rules();
        test_invalid_dates();
        test_random_mixed(600);
        test_drain_pause();
        test_field_noise(180);
        test_random_mixed(250);

        // closing phase: no idling on either side
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        test_random_mixed(200);

        i_s_axis_tvalid <= 1'b0;
        while (expected_results_q.size() != 0) @(posedge i_clk);
        // pipe is five deep; give stray beats time to show up
        repeat (20) @(posedge i_clk);

        $display("Sent %0d date pairs (%0d invalid dates replaced), %0d results checked,",
                 requests_sent, invalid_dates, results_checked);
        $display("covering range ends, leap and century rules, bad fields and back-pressure.");
        if (mismatch_count == 0 && expected_results_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_results_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
